// ===== hw/rtl/bresenham_line_rasterizer_assert.svh =====
// Assertion macros shared by the line rasterizer modules.
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define BLR_ASSERT_SAME(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("line rasterizer check failed in the same cycle");

// The consequence must hold in the cycle after the condition.
`define BLR_ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("line rasterizer check failed in the following cycle");

`endif

// ===== hw/rtl/blr_pkg.sv =====
// Package with the types and constants of the line rasterizer.
`default_nettype none

package blr_pkg;

  // Coordinate and arithmetic widths.
  localparam int COORD_BITS     = 10;
  localparam int DIM_BITS       = 10;
  localparam int COLOR_BITS     = 32;
  localparam int ERR_BITS       = COORD_BITS + 3;
  localparam int CFG_INDEX_BITS = 1;

  // Command codes.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RESET  = 10'd240;
  localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET = 10'd240;

  // One input item.
  typedef struct packed {
    logic                  command;
    logic [COORD_BITS-1:0] from_x;
    logic [COORD_BITS-1:0] from_y;
    logic [COORD_BITS-1:0] to_x;
    logic [COORD_BITS-1:0] to_y;
    logic [COLOR_BITS-1:0] line_color;
  } blr_in_t;

  // One result item.
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  on_screen;
    logic                  last_pixel;
  } blr_out_t;

  // Classified command with its line set-up, as held in the queue.
  typedef struct packed {
    logic                        is_load;
    logic [COORD_BITS-1:0]       from_x;
    logic [COORD_BITS-1:0]       from_y;
    logic [COORD_BITS-1:0]       to_x;
    logic [COORD_BITS-1:0]       to_y;
    logic [COORD_BITS-1:0]       span_x;
    logic [COORD_BITS-1:0]       span_y;
    logic                        step_x_down;
    logic                        step_y_down;
    logic signed [ERR_BITS-1:0]  err_init;
    logic [COLOR_BITS-1:0]       color;
  } blr_cmd_t;

  // Screen limits handed to the stepping stage.
  typedef struct packed {
    logic [DIM_BITS-1:0] screen_width;
    logic [DIM_BITS-1:0] screen_height;
  } blr_screen_t;

endpackage

`default_nettype wire

// ===== hw/rtl/blr_front.sv =====
// Front stage: accepts commands, classifies them and works out the line set-up.
`default_nettype none

module blr_front
  import blr_pkg::*;
(
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire blr_in_t  in_data,
  input  wire logic     queue_full,
  output logic          push,
  output blr_cmd_t      push_data
);

  logic x_up;
  logic y_up;

  // A command is taken whenever the queue has room.
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Direction of travel on each axis; equal coordinates count as stepping down.
  assign x_up = in_data.from_x < in_data.to_x;
  assign y_up = in_data.from_y < in_data.to_y;

  // Absolute spans, step directions and the starting error term.
  always_comb begin
    push_data.is_load     = (in_data.command == CMD_LOAD);
    push_data.from_x      = in_data.from_x;
    push_data.from_y      = in_data.from_y;
    push_data.to_x        = in_data.to_x;
    push_data.to_y        = in_data.to_y;
    push_data.span_x      = x_up ? (in_data.to_x - in_data.from_x)
                                 : (in_data.from_x - in_data.to_x);
    push_data.span_y      = y_up ? (in_data.to_y - in_data.from_y)
                                 : (in_data.from_y - in_data.to_y);
    push_data.step_x_down = !x_up;
    push_data.step_y_down = !y_up;
    push_data.err_init    = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, push_data.span_x})
                          - $signed({{(ERR_BITS-COORD_BITS){1'b0}}, push_data.span_y});
    push_data.color       = in_data.line_color;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/blr_queue.sv =====
// Short command queue between the front and the stepping stage.
`default_nettype none

module blr_queue
  import blr_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire blr_cmd_t push_data,
  output logic          full,
  output logic          pop_valid,
  input  wire logic     pop,
  output blr_cmd_t      pop_data
);

  `include "bresenham_line_rasterizer_assert.svh"

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  blr_cmd_t            entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full      = (count == CNT_BITS'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // Storage is written at the write pointer on every transfer in.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the depth; the count follows pushes and pops.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `BLR_ASSERT_SAME(a_count_bounded, clk, rst, 1'b1, count <= CNT_BITS'(DEPTH))
  `BLR_ASSERT_SAME(a_no_pop_empty, clk, rst, pop, count != '0)
  `BLR_ASSERT_SAME(a_no_push_full, clk, rst, push, !full)

endmodule

`default_nettype wire

// ===== hw/rtl/blr_back.sv =====
// Stepping stage: keeps the line state and emits one pixel per advance while a line is in progress.
`default_nettype none

module blr_back
  import blr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire blr_screen_t screen,
  input  wire logic        cmd_valid,
  input  wire blr_cmd_t    cmd,
  output logic             cmd_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output blr_out_t         out_data
);

  `include "bresenham_line_rasterizer_assert.svh"

  logic                       busy;
  logic [COORD_BITS-1:0]      pos_x;
  logic [COORD_BITS-1:0]      pos_y;
  logic [COORD_BITS-1:0]      target_x;
  logic [COORD_BITS-1:0]      target_y;
  logic [COORD_BITS-1:0]      span_x;
  logic [COORD_BITS-1:0]      span_y;
  logic                       step_x_down;
  logic                       step_y_down;
  logic signed [ERR_BITS-1:0] err_acc;
  logic [COLOR_BITS-1:0]      held_color;

  logic                       back_go;
  logic                       emit;
  logic signed [ERR_BITS-1:0] err_x2;
  logic signed [ERR_BITS-1:0] span_x_s;
  logic signed [ERR_BITS-1:0] span_y_s;
  logic                       x_test;
  logic                       y_test;
  logic                       x_done;
  logic                       done;
  logic                       step_x;
  logic                       step_y;
  logic signed [ERR_BITS-1:0] err_acc_next;

  // The stage moves when its output register is empty or being drained.
  assign back_go = !out_valid || !out_stall;
  assign cmd_pop = cmd_valid && back_go;
  assign emit    = cmd_pop && !cmd.is_load && busy;

  // Both axis tests use the doubled error taken before any update.
  assign err_x2   = err_acc <<< 1;
  assign span_x_s = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, span_x});
  assign span_y_s = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, span_y});
  assign x_test   = err_x2 >= -span_y_s;
  assign y_test   = err_x2 <= span_x_s;
  assign x_done   = x_test && (pos_x == target_x);
  assign done     = x_done || (y_test && (pos_y == target_y));
  assign step_x   = x_test && (pos_x != target_x);
  assign step_y   = !x_done && y_test && (pos_y != target_y);

  always_comb begin
    err_acc_next = err_acc;
    if (step_x) begin
      err_acc_next = err_acc_next - span_y_s;
    end
    if (step_y) begin
      err_acc_next = err_acc_next + span_x_s;
    end
  end

  // Line state: a load replaces it, an advance steps it.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd_pop) begin
      if (cmd.is_load) begin
        busy <= 1'b1;
      end else if (busy && done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.is_load) begin
      pos_x       <= cmd.from_x;
      pos_y       <= cmd.from_y;
      target_x    <= cmd.to_x;
      target_y    <= cmd.to_y;
      span_x      <= cmd.span_x;
      span_y      <= cmd.span_y;
      step_x_down <= cmd.step_x_down;
      step_y_down <= cmd.step_y_down;
      err_acc     <= cmd.err_init;
      held_color  <= cmd.color;
    end else if (emit) begin
      err_acc <= err_acc_next;
      if (step_x) begin
        pos_x <= step_x_down ? pos_x - 1'b1 : pos_x + 1'b1;
      end
      if (step_y) begin
        pos_y <= step_y_down ? pos_y - 1'b1 : pos_y + 1'b1;
      end
    end
  end

  // Output register: holds a pixel until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (back_go) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.pixel_x     <= pos_x;
      out_data.pixel_y     <= pos_y;
      out_data.pixel_color <= held_color;
      out_data.on_screen   <= (pos_x < screen.screen_width)
                           && (pos_y < screen.screen_height);
      out_data.last_pixel  <= done;
    end
  end

  `BLR_ASSERT_NEXT(a_last_goes_idle, clk, rst, emit && done, !busy)
  `BLR_ASSERT_NEXT(a_load_goes_busy, clk, rst, cmd_pop && cmd.is_load, busy)
  `BLR_ASSERT_NEXT(a_emit_shows_pixel, clk, rst, emit, out_valid)

endmodule

`default_nettype wire

// ===== hw/rtl/bresenham_line_rasterizer.sv =====
// Top level of the line rasterizer: configuration registers and stage wiring.
//
// Usage: the input channel (in_valid, in_stall, in_data) carries commands.
// A load command latches two endpoints and a colour and gives no result.
// Each advance command emits the current pixel of the line on the output
// channel (out_valid, out_stall, out_data) and steps towards the end point;
// the end point is flagged as the last pixel, and advances with no line in
// progress give no result. A transfer happens on a rising edge with valid
// high and stall low.
// An accepted advance waits in the queue until the stepping stage takes it;
// its pixel is then registered in the output register. Throughput: one
// command per cycle while the output is not stalled; the stepping stage
// computes its error update combinationally, and a small command queue
// decouples front and back. A stalled receiver holds the output register;
// the queue then fills and in_stall rises once it is full. Screen width and
// height are written through cfg_write, cfg_index and cfg_data; the user must
// write them only while the block is idle, which the block itself does not
// enforce; both reset to 240. Reset (rst, synchronous) empties the queue
// and output and leaves the block with no line in progress.
`default_nettype none

module bresenham_line_rasterizer
  import blr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [DIM_BITS-1:0]       cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire blr_in_t                   in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output blr_out_t                       out_data
);

  blr_screen_t screen;
  logic        queue_full;
  logic        push;
  blr_cmd_t    push_data;
  logic        cmd_valid;
  logic        cmd_pop;
  blr_cmd_t    cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen.screen_width  <= SCREEN_WIDTH_RESET;
      screen.screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCREEN_WIDTH: begin
          screen.screen_width <= cfg_data;
        end
        REG_SCREEN_HEIGHT: begin
          screen.screen_height <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Command intake and set-up.
  blr_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // Queue between the two sides.
  blr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop_valid (cmd_valid),
    .pop       (cmd_pop),
    .pop_data  (cmd)
  );

  // Line stepping and pixel output.
  blr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .screen    (screen),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
